### rtl/crc16fa_pkg.sv
// shared types, constants and the crc byte fold for the crc16 frame appender
// no dependencies; used by every module under rtl
`default_nettype none

package crc16fa_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [7:0]  ZERO_BYTE = 8'h00;

    // zero-slot fold phase after a last byte
    typedef enum logic [1:0] {
        FOLD_IDLE,
        FOLD_FIRST,
        FOLD_SECOND
    } t_fold;

    // queue entry passed from front to back
    typedef struct packed {
        logic        is_tail;   // 1: payload is the final crc, 0: payload[7:0] is a data byte
        logic [15:0] payload;
    } t_qentry;

    // fold one byte into the crc, msb first, eight shift steps
    function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic [7:0]  d;
        c = crc;
        d = data;
        for (int b = 0; b < 8; b++) begin
            if (c[15] ^ d[7]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/crc16fa_fifo.sv
// short request queue between the front and back parts of the crc16 frame appender
// depends on crc16fa_pkg for the entry type
`default_nettype none

module crc16fa_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  crc16fa_pkg::t_qentry    i_push_entry,
    output logic                    o_full,
    input  wire                     i_pop,
    output crc16fa_pkg::t_qentry    o_pop_entry,
    output logic                    o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    crc16fa_pkg::t_qentry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full      = (r_count == FULL_CNT);
    assign o_empty     = (r_count == '0);
    assign o_pop_entry = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

`default_nettype wire

### rtl/crc16fa_front.sv
// front part: accepts frame bytes, keeps the running crc, folds the two zero slots
// depends on crc16fa_pkg; pushes data and tail requests into crc16fa_fifo
`default_nettype none

module crc16fa_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [7:0]              i_data_byte,
    input  wire                     i_first_byte,
    input  wire                     i_last_byte,
    output logic                    o_push,
    output crc16fa_pkg::t_qentry    o_push_entry,
    input  wire                     i_full
);

    crc16fa_pkg::t_fold r_fold, n_fold;
    logic [15:0] r_crc, n_crc;
    logic [15:0] crc_base, crc_zero;
    logic        accept;

    assign crc_base = i_first_byte ? crc16fa_pkg::CRC_INIT : r_crc;
    assign crc_zero = crc16fa_pkg::fold_byte(r_crc, crc16fa_pkg::ZERO_BYTE);
    assign o_ready  = (r_fold == crc16fa_pkg::FOLD_IDLE) && !i_full;
    assign accept   = i_valid && o_ready;

    // crc update and request generation
    always_comb begin
        n_fold       = r_fold;
        n_crc        = r_crc;
        o_push       = 1'b0;
        o_push_entry = '{is_tail: 1'b0, payload: {8'h00, i_data_byte}};
        unique case (r_fold)
            crc16fa_pkg::FOLD_IDLE: begin
                if (accept) begin
                    o_push = 1'b1;
                    n_crc  = crc16fa_pkg::fold_byte(crc_base, i_data_byte);
                    if (i_last_byte) begin
                        n_fold = crc16fa_pkg::FOLD_FIRST;
                    end
                end
            end
            crc16fa_pkg::FOLD_FIRST: begin
                n_crc  = crc_zero;
                n_fold = crc16fa_pkg::FOLD_SECOND;
            end
            crc16fa_pkg::FOLD_SECOND: begin
                o_push_entry = '{is_tail: 1'b1, payload: crc_zero};
                if (!i_full) begin
                    o_push = 1'b1;
                    n_crc  = crc_zero;
                    n_fold = crc16fa_pkg::FOLD_IDLE;
                end
            end
            default: begin
                n_fold = crc16fa_pkg::FOLD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= crc16fa_pkg::FOLD_IDLE;
            r_crc  <= crc16fa_pkg::CRC_INIT;
        end else begin
            r_fold <= n_fold;
            r_crc  <= n_crc;
        end
    end

endmodule

`default_nettype wire

### rtl/crc16fa_back.sv
// back part: turns queued requests into output bytes, crc low then high for a tail
// depends on crc16fa_pkg; pops from crc16fa_fifo
`default_nettype none

module crc16fa_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  crc16fa_pkg::t_qentry    i_entry,
    input  wire                     i_empty,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [7:0]              o_out_byte,
    output logic                    o_end_of_frame
);

    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_eof, n_eof;
    logic       r_hi_pend, n_hi_pend;
    logic [7:0] r_hi_byte, n_hi_byte;
    logic       load;

    assign load           = !r_valid || i_ready;
    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_end_of_frame = r_eof;

    // output register loading, high crc byte has priority over the queue
    always_comb begin
        n_valid   = r_valid;
        n_byte    = r_byte;
        n_eof     = r_eof;
        n_hi_pend = r_hi_pend;
        n_hi_byte = r_hi_byte;
        o_pop     = 1'b0;
        if (load) begin
            priority if (r_hi_pend) begin
                n_valid   = 1'b1;
                n_byte    = r_hi_byte;
                n_eof     = 1'b1;
                n_hi_pend = 1'b0;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_eof   = 1'b0;
                n_byte  = i_entry.payload[7:0];
                if (i_entry.is_tail) begin
                    n_hi_pend = 1'b1;
                    n_hi_byte = i_entry.payload[15:8];
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_hi_pend <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_hi_pend <= n_hi_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_eof     <= n_eof;
        r_hi_byte <= n_hi_byte;
    end

endmodule

`default_nettype wire

### rtl/crc16_frame_appender.sv
// top level of the crc16 frame appender: front, request queue and back part
// depends on crc16fa_pkg, crc16fa_front, crc16fa_fifo and crc16fa_back
//
// channel   direction  tdata              tuser        tlast
// s_axis    in         data_byte[7:0]     first_byte   last_byte
// m_axis    out        out_byte[7:0]      -            end_of_frame
//
// ordinary bytes go one per cycle in and out unless the queue fills or m_axis stalls
// after a last byte the front folds the two zero slots one per cycle
// and the back sends crc low then crc high from its output register
// the queue of QUEUE_DEPTH requests lets the front keep taking bytes while m_axis stalls
// reset is synchronous, active low; it clears the crc, the queue and the output valid
`default_nettype none

module crc16_frame_appender #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,    // [7:0] data_byte
    input  wire        s_axis_tuser,    // [0] first_byte
    input  wire        s_axis_tlast,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast
);

    crc16fa_pkg::t_qentry push_entry, pop_entry;
    logic push, pop, full, empty;

    // accept and fold
    crc16fa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data_byte  (s_axis_tdata),
        .i_first_byte (s_axis_tuser),
        .i_last_byte  (s_axis_tlast),
        .o_push       (push),
        .o_push_entry (push_entry),
        .i_full       (full)
    );

    // request queue
    crc16fa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_pop_entry  (pop_entry),
        .o_empty      (empty)
    );

    // output bytes
    crc16fa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (pop_entry),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_out_byte     (m_axis_tdata),
        .o_end_of_frame (m_axis_tlast)
    );

endmodule

`default_nettype wire
